FILE: rtl/core/bcs_pkg.sv
`timescale 1ns / 1ps

package bcs_pkg;

  localparam int MAX_BANKS = 8;
  localparam int CNT_W     = $clog2(MAX_BANKS + 1);
  localparam int CMP_W     = (CNT_W > 4) ? CNT_W : 4;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEDS_EN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BANK_CNT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(3);

  localparam logic [2:0] MODE_SWITCH = 3'd0;
  localparam logic [2:0] MODE_TOGGLE = 3'd1;
  localparam logic [2:0] MODE_PER_BANK = 3'd2;
  localparam logic [2:0] MODE_UP_DOWN = 3'd3;
  localparam logic [2:0] MODE_UP_ONLY = 3'd4;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        level_a;
    logic        level_b;
    logic [7:0]  bank_levels;
  } bcs_in_t;

  typedef struct packed {
    logic [3:0] channel;
    logic       changed;
    logic [7:0] led_pattern;
  } bcs_out_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        leds_enabled;
    logic [3:0]  bank_count;
    logic [15:0] debounce_ms;
  } bcs_cfg_t;

  typedef struct packed {
    logic [3:0]  current_channel;
    logic        prev_level_a;
    logic        prev_level_b;
    logic [31:0] last_bounce_ms;
  } bcs_state_t;

endpackage

FILE: rtl/core/bank_channel_selector_top.sv
`timescale 1ns / 1ps

// Bank channel selector.
// Input channel (in_valid/in_ready/in_data): one beat per sample of the
// active-low button levels and a millisecond timestamp.
// Result channel (out_valid/out_ready/out_data): one beat per input beat,
// carrying the selected channel, a changed flag and the LED pattern.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_wdata): index 0
// mode, 1 LED enable, 2 bank count, 3 debounce time; cfg_ready is always high.
// Path: an accepted sample is held in the input register, is evaluated
// against the channel state, and its result is loaded into the result
// register once that register is empty or its beat is taken.
// Throughput: one sample per cycle while out_ready is high; the channel
// state update is a single combinational pass between the input and result registers.
// Reset: channel 1, both buttons released, last bounce time zero, registers
// at their defaults; no beats are held.
// Stall: while out_ready is low the result holds, the input register fills
// and in_ready drops until the result is taken.
module bank_channel_selector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bcs_pkg::bcs_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bcs_pkg::bcs_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcs_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  bcs_pkg::bcs_cfg_t   cfg;
  bcs_pkg::bcs_state_t st_r;
  bcs_pkg::bcs_state_t st_nxt;
  bcs_pkg::bcs_in_t    smp_r;
  bcs_pkg::bcs_out_t   res;
  bcs_pkg::bcs_out_t   out_r;
  logic                smp_valid_r;
  logic                out_valid_r;
  logic                adv;

  assign cfg_ready = 1'b1;

  bcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  bcs_update u_upd (
    .cfg    (cfg),
    .st     (st_r),
    .smp    (smp_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign adv      = smp_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !smp_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r             <= 1'b0;
      out_valid_r             <= 1'b0;
      st_r.current_channel    <= 4'd1;
      st_r.prev_level_a       <= 1'b1;
      st_r.prev_level_b       <= 1'b1;
      st_r.last_bounce_ms     <= 32'd0;
    end else begin
      if (in_valid && in_ready) begin
        smp_valid_r <= 1'b1;
      end else if (adv) begin
        smp_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) smp_r <= in_data;
    if (adv) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_chan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.channel != 4'd0))
    else $error("result channel is zero");

  a_state_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (st_r.current_channel == out_r.channel))
    else $error("channel state and result disagree");

  a_led_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_r.led_pattern))
    else $error("LED pattern not one-hot");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (smp_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

endmodule

FILE: rtl/core/bcs_cfg_regs.sv
`timescale 1ns / 1ps

module bcs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcs_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output bcs_pkg::bcs_cfg_t              cfg_o
);

  bcs_pkg::bcs_cfg_t cfg_r;
  bcs_pkg::bcs_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        bcs_pkg::REG_MODE:     cfg_nxt.mode         = cfg_wdata[2:0];
        bcs_pkg::REG_LEDS_EN:  cfg_nxt.leds_enabled = cfg_wdata[0];
        bcs_pkg::REG_BANK_CNT: cfg_nxt.bank_count   = cfg_wdata[3:0];
        bcs_pkg::REG_DEBOUNCE: cfg_nxt.debounce_ms  = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= bcs_pkg::MODE_SWITCH;
      cfg_r.leds_enabled <= 1'b0;
      cfg_r.bank_count   <= 4'd2;
      cfg_r.debounce_ms  <= 16'd25;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

FILE: rtl/core/bcs_update.sv
`timescale 1ns / 1ps

module bcs_update (
  input  bcs_pkg::bcs_cfg_t   cfg,
  input  bcs_pkg::bcs_state_t st,
  input  bcs_pkg::bcs_in_t    smp,
  output bcs_pkg::bcs_state_t st_nxt,
  output bcs_pkg::bcs_out_t   res
);

  logic [bcs_pkg::CMP_W-1:0] n_eff;
  logic [bcs_pkg::CMP_W-1:0] ch_w;
  logic [3:0]  ch;
  logic [3:0]  up_ch;
  logic [3:0]  dn_ch;
  logic [3:0]  scan_ch;
  logic [3:0]  next_ch;
  logic [3:0]  lim;
  logic        found;
  logic        use_a;
  logic        use_b;
  logic        elapsed_ok;
  logic        press_a;
  logic        press_b;
  logic        upd_a;
  logic        upd_b;
  logic [31:0] elapsed;
  logic [7:0]  leds;

  always_comb begin
    if (cfg.bank_count == 4'd0) begin
      n_eff = bcs_pkg::CMP_W'(1);
    end else if (int'(cfg.bank_count) > bcs_pkg::MAX_BANKS) begin
      n_eff = bcs_pkg::CMP_W'(bcs_pkg::MAX_BANKS);
    end else begin
      n_eff = bcs_pkg::CMP_W'(cfg.bank_count);
    end
  end

  assign ch    = st.current_channel;
  assign ch_w  = bcs_pkg::CMP_W'(ch);
  assign up_ch = (ch_w >= n_eff) ? 4'd1 : ch + 4'd1;
  assign dn_ch = (ch <= 4'd1) ? n_eff[3:0] : ch - 4'd1;

  assign use_a = (cfg.mode == bcs_pkg::MODE_TOGGLE) || (cfg.mode == bcs_pkg::MODE_UP_DOWN)
              || (cfg.mode == bcs_pkg::MODE_UP_ONLY);
  assign use_b = (cfg.mode == bcs_pkg::MODE_UP_DOWN);

  assign elapsed    = smp.now_ms - st.last_bounce_ms;
  assign elapsed_ok = elapsed > {16'd0, cfg.debounce_ms};

  // timer restarts on a counted press or on a release
  assign press_a = use_a && st.prev_level_a && !smp.level_a && elapsed_ok;
  assign upd_a   = press_a || (use_a && !st.prev_level_a && smp.level_a);
  // after an update by the up button the elapsed time is zero: no second press
  assign press_b = use_b && st.prev_level_b && !smp.level_b && elapsed_ok && !upd_a;
  assign upd_b   = press_b || (use_b && !st.prev_level_b && smp.level_b);

  always_comb begin
    lim     = (n_eff > bcs_pkg::CMP_W'(8)) ? 4'd8 : n_eff[3:0];
    found   = 1'b0;
    scan_ch = ch;
    for (int i = 0; i < 8; i++) begin
      if (!found && (4'(i) < lim) && !smp.bank_levels[i]) begin
        found   = 1'b1;
        scan_ch = 4'(i + 1);
      end
    end
  end

  always_comb begin
    next_ch = ch;
    case (cfg.mode)
      bcs_pkg::MODE_SWITCH:   next_ch = smp.level_a ? 4'd1 : 4'd2;
      bcs_pkg::MODE_TOGGLE:   if (press_a) next_ch = (ch == 4'd1) ? 4'd2 : 4'd1;
      bcs_pkg::MODE_PER_BANK: next_ch = scan_ch;
      bcs_pkg::MODE_UP_DOWN: begin
        if (press_a) next_ch = up_ch;
        if (press_b) next_ch = dn_ch;
      end
      bcs_pkg::MODE_UP_ONLY:  if (press_a) next_ch = up_ch;
      default: ;
    endcase
  end

  always_comb begin
    leds = 8'd0;
    if (cfg.leds_enabled) begin
      if (cfg.mode inside {bcs_pkg::MODE_SWITCH, bcs_pkg::MODE_TOGGLE}) begin
        leds = (next_ch == 4'd2) ? 8'd1 : 8'd0;
      end else if (cfg.mode inside {[bcs_pkg::MODE_PER_BANK : bcs_pkg::MODE_UP_ONLY]}) begin
        if (next_ch inside {[4'd1 : 4'd8]}) leds = 8'd1 << (next_ch - 4'd1);
      end
    end
  end

  always_comb begin
    st_nxt.current_channel = next_ch;
    st_nxt.prev_level_a    = use_a ? smp.level_a : st.prev_level_a;
    st_nxt.prev_level_b    = use_b ? smp.level_b : st.prev_level_b;
    st_nxt.last_bounce_ms  = (upd_a || upd_b) ? smp.now_ms : st.last_bounce_ms;
  end

  assign res.channel     = next_ch;
  assign res.changed     = (next_ch != ch);
  assign res.led_pattern = leds;

endmodule
